// ===== design/audio_soft_clip_compressor_macros.svh =====
// assertion macros used by the soft clipper settle module
`ifndef AUDIO_SOFT_CLIP_COMPRESSOR_MACROS_SVH
`define AUDIO_SOFT_CLIP_COMPRESSOR_MACROS_SVH

// condition holds at every edge outside reset
`define SCC_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("soft clipper check failed");

// antecedent implies consequent in the same cycle
`define SCC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("soft clipper check failed");

// antecedent implies consequent in the next cycle
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("soft clipper check failed");

`endif

// ===== design/scc_pkg.sv =====
`timescale 1ns / 1ps

package scc_pkg;

    localparam logic [15:0] SEG_SIZE   = 16'd16384;
    localparam logic [15:0] FULL_SCALE = 16'd32768;
    localparam logic [15:0] NEG_BASE   = 16'd49152;
    localparam logic [15:0] POS_TOP    = 16'd65535;
    localparam logic [4:0]  STEP_CAP   = 5'd16;
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam logic [15:0] MOST_NEG   = 16'h8000;

    typedef struct packed {
        logic        neg;
        logic [4:0]  steps;
        logic [31:0] scaled;
    } front_t;

endpackage

// ===== design/scc_in_if.sv =====
`timescale 1ns / 1ps

interface scc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/scc_out_if.sv =====
`timescale 1ns / 1ps

interface scc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ===== design/scc_front.sv =====
`timescale 1ns / 1ps

module scc_front
    import scc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample_in,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    logic        v1_reg;
    logic        v2_reg;
    logic        adv1;
    logic        adv2;
    logic [13:0] low;
    logic [15:0] fac_a;
    logic [14:0] fac_b;
    logic [16:0] seg;
    logic [4:0]  steps_next;
    logic [30:0] prod1_next;
    logic [29:0] prod1_reg;
    logic        neg1_reg;
    logic [4:0]  steps1_reg;
    logic [15:0] quot;
    logic [31:0] prod2_next;
    front_t      front_reg;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // parabola operands and segment count
    always_comb
    begin
        low = sample_in[13:0];
        if (sample_in[31])
        begin
            fac_a = NEG_BASE + {2'b00, low};
            fac_b = SEG_SIZE[14:0] - {1'b0, low};
            seg   = ~sample_in[30:14];
        end
        else
        begin
            fac_a = POS_TOP - {2'b00, low};
            fac_b = {1'b0, low};
            seg   = sample_in[30:14];
        end
        steps_next = (seg > {12'd0, STEP_CAP}) ? STEP_CAP : seg[4:0];
        prod1_next = fac_a * fac_b;
    end

    // divide by 3 through the reciprocal
    assign quot       = prod1_reg[29:14];
    assign prod2_next = quot * DIV3_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            prod1_reg  <= prod1_next[29:0];
            neg1_reg   <= sample_in[31];
            steps1_reg <= steps_next;
        end
        if (adv2 && v1_reg)
        begin
            front_reg.neg    <= neg1_reg;
            front_reg.steps  <= steps1_reg;
            front_reg.scaled <= prod2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = front_reg;

endmodule

// ===== design/scc_settle.sv =====
`timescale 1ns / 1ps

`include "audio_soft_clip_compressor_macros.svh"

module scc_settle
    import scc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  front_t             in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out
);

    logic        v3_reg;
    logic        v4_reg;
    logic        adv3;
    logic        adv4;
    logic [14:0] mag;
    logic [15:0] dist_next;
    logic [15:0] dist3_reg;
    logic        neg3_reg;
    logic [4:0]  steps3_reg;
    logic [15:0] rnd_mask;
    logic [15:0] dist_k;
    logic [15:0] mag_out;
    logic [15:0] res_next;
    logic [15:0] res_reg;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign in_ready = adv3;

    // distance from full scale, each halving step rounds it up
    assign mag       = in_data.scaled[31:17];
    assign dist_next = FULL_SCALE - {1'b0, mag};

    always_comb
    begin
        rnd_mask = (16'd1 << steps3_reg) - 16'd1;
        dist_k   = (dist3_reg >> steps3_reg) + {15'd0, |(dist3_reg & rnd_mask)};
        mag_out  = FULL_SCALE - dist_k;
        res_next = neg3_reg ? (16'd0 - mag_out) : mag_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                v3_reg <= in_valid;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && in_valid)
        begin
            dist3_reg  <= dist_next;
            neg3_reg   <= in_data.neg;
            steps3_reg <= in_data.steps;
        end
        if (adv4 && v3_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = v4_reg;
    assign sample_out = res_reg;

    `SCC_ASSERT_IMPLIES(a_steps_capped, v3_reg, steps3_reg <= STEP_CAP)
    `SCC_ASSERT_IMPLIES(a_dist_range, v3_reg, (dist3_reg >= SEG_SIZE) && (dist3_reg <= FULL_SCALE))
    `SCC_ASSERT_IMPLIES(a_no_most_neg, v4_reg, res_reg != MOST_NEG)
    `SCC_ASSERT_NEXT(a_stall_holds_result, v4_reg && !out_ready, v4_reg && $stable(res_reg))

endmodule

// ===== design/audio_soft_clip_compressor.sv =====
`timescale 1ns / 1ps

// port    role   payload
// feed    sink   sample_in  (signed 32 bits)
// result  source sample_out (signed 16 bits)
//
// four register stages: parabola product, reciprocal divide, distance, settle
// one request per cycle unless a result stall holds the full pipeline; each passes all four register stages
// asynchronous active-low reset empties the pipeline, there is no other state
// a stalled result holds its stage; bubbles fill up until feed.ready falls

module audio_soft_clip_compressor
    import scc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    scc_in_if.sink    feed,
    scc_out_if.source result
);

    logic   mid_valid;
    logic   mid_ready;
    front_t mid_data;

    scc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feed.valid),
        .in_ready  (feed.ready),
        .sample_in (feed.sample_in),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    scc_settle u_settle (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_data    (mid_data),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .sample_out (result.sample_out)
    );

endmodule

// ===== tb/tb_audio_soft_clip_compressor.sv =====
`timescale 1ns / 1ps

module tb_audio_soft_clip_compressor;

    localparam int unsigned SEG         = 16384;
    localparam int unsigned FULL        = 32768;
    localparam int unsigned TOP         = 65535;
    localparam int unsigned WRAP        = 65536;
    localparam int unsigned CAP         = 16;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam int unsigned DIR_ROWS    = 20;

    typedef struct packed {
        logic [31:0] sample;
        logic [15:0] level;
    } clip_t;

    typedef struct packed {
        logic [31:0] sample;
        logic        typed;
        logic [15:0] level;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    scc_in_if  feed();
    scc_out_if result();

    audio_soft_clip_compressor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .result (result)
    );

    clip_t       pending_q[$];
    clip_t       head;
    dir_row_t    dir_rows[0:DIR_ROWS-1];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;

    function automatic logic [15:0] soft_clip(input logic [31:0] s);
        longint unsigned low;
        longint unsigned span;
        longint unsigned mag;
        longint unsigned steps;
        longint unsigned neg_mag;
        longint unsigned res;
        int              k;
        low = s[13:0];
        if (!s[31])
        begin
            mag   = ((TOP - low) * low / SEG) / 3;
            steps = s >> 14;
        end
        else
        begin
            span    = SEG - low;
            mag     = ((WRAP - span) * span / SEG) / 3;
            neg_mag = 64'h1_0000_0000 - s;
            steps   = (neg_mag - 1) / SEG;
        end
        if (steps > CAP)
            steps = CAP;
        for (k = 0; k < steps; k++)
            mag = (mag + FULL) >> 1;
        res = s[31] ? WRAP - mag : mag;
        return res[15:0];
    endfunction

    function automatic logic [31:0] pick_sample();
        int unsigned kind;
        int unsigned seg_idx;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom_range(0, 34 * SEG) - 17 * SEG;
        else if (kind < 7)
        begin
            seg_idx = $urandom_range(0, 40);
            return seg_idx * SEG - 20 * SEG + $urandom_range(0, 4) - 2;
        end
        else
            return $urandom;
    endfunction

    task automatic send(input logic [31:0] s, input logic [15:0] level);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            feed.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        feed.valid     <= 1'b1;
        feed.sample_in <= s;
        @(posedge clk);
        while (!feed.ready)
            @(posedge clk);
        pending_q.push_back('{s, level});
    endtask

    task automatic send_random(input int unsigned count);
        logic [31:0] s;
        repeat (count)
        begin
            s = pick_sample();
            send(s, soft_clip(s));
        end
    endtask

    task automatic wait_drained();
        feed.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result %0d with nothing pending", result.sample_out);
            end
            else
            begin
                head = pending_q.pop_front();
                if (result.sample_out !== head.level)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch for sample %0d: expected %0d, got %0d",
                                 $signed(head.sample), $signed(head.level),
                                 result.sample_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (feed.valid && feed.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("audio_soft_clip_compressor test failed");
                $finish;
            end
        end
    end

    initial
    begin
        feed.valid     = 1'b0;
        feed.sample_in = '0;

        dir_rows[0]  = '{32'h0000_0000, 1'b1, 16'h0000};
        dir_rows[1]  = '{32'h0000_0001, 1'b1, 16'h0001};
        dir_rows[2]  = '{32'h0000_3FFF, 1'b1, 16'h3FFF};
        dir_rows[3]  = '{32'h0000_4000, 1'b1, 16'h4000};
        dir_rows[4]  = '{32'h0000_8000, 1'b1, 16'h6000};
        dir_rows[5]  = '{32'h7FFF_FFFF, 1'b1, 16'h7FFF};
        dir_rows[6]  = '{32'hFFFF_FFFF, 1'b1, 16'hFFFF};
        dir_rows[7]  = '{32'hFFFF_C000, 1'b1, 16'hC000};
        dir_rows[8]  = '{32'hFFFF_8000, 1'b1, 16'hA000};
        dir_rows[9]  = '{32'h8000_0000, 1'b1, 16'h8001};
        // segment edges on the negative side
        dir_rows[10] = '{32'hFFFF_C001, 1'b0, 16'h0000};
        dir_rows[11] = '{32'hFFFF_BFFF, 1'b0, 16'h0000};
        // step cap reached exactly and passed, then points inside low segments
        dir_rows[12] = '{32'h0004_0000, 1'b0, 16'h0000};
        dir_rows[13] = '{32'h0004_4005, 1'b0, 16'h0000};
        dir_rows[14] = '{32'hFFFB_FFFF, 1'b0, 16'h0000};
        dir_rows[15] = '{32'h5555_5555, 1'b0, 16'h0000};
        dir_rows[16] = '{32'hAAAA_AAAA, 1'b0, 16'h0000};
        dir_rows[17] = '{32'h0000_2000, 1'b0, 16'h0000};
        dir_rows[18] = '{32'hFFFF_E000, 1'b0, 16'h0000};
        dir_rows[19] = '{32'h0000_FFFF, 1'b0, 16'h0000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send(dir_rows[i].sample,
                 dir_rows[i].typed ? dir_rows[i].level : soft_clip(dir_rows[i].sample));

        send_random(800);

        // long result stall while requests keep coming
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_random(40);
        gaps_on  = 1'b1;

        wait_drained();

        send_random(700);
        gaps_on = 1'b0;
        send_random(160);

        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_q.size() == 0)
            $display("audio_soft_clip_compressor test passed");
        else
            $display("audio_soft_clip_compressor test failed");
        $finish;
    end

endmodule
